/* hw/rtl/cts_pkg.sv */
`default_nettype none
package cts_pkg;

    localparam int PASSES   = 3;
    localparam int COUNT_W  = 20;
    localparam int SAMPLE_W = 22;
    localparam int SUM3_W   = SAMPLE_W + 2;
    localparam int PROD_W   = 2 * SUM3_W;

    // floor(x / 3) = (x * DIV3_MUL) >> DIV3_SHIFT for every SUM3_W-bit x
    localparam int DIV3_SHIFT = SUM3_W + 1;
    localparam logic [SUM3_W-1:0] DIV3_MUL = SUM3_W'(((1 << DIV3_SHIFT) + 2) / 3);

    typedef struct packed {
        logic [COUNT_W-1:0] count_a;
        logic [COUNT_W-1:0] count_b;
        logic [COUNT_W-1:0] count_c;
        logic [COUNT_W-1:0] count_d;
        logic               is_final;
    } t_in_item;

    typedef struct packed {
        logic [SAMPLE_W-1:0] smoothed;
        logic                ends_sequence;
    } t_out_item;

    // one sample moving between stages
    typedef struct packed {
        logic                fin;
        logic [SAMPLE_W-1:0] val;
    } t_tok;

endpackage
`default_nettype wire

/* hw/rtl/cts_sum.sv */
`default_nettype none
module cts_sum
    import cts_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire t_in_item i_item,
    output logic          o_stall,
    output logic          o_valid,
    output t_tok          o_tok,
    input  wire logic     i_stall
);

    logic r_vld;
    t_tok r_tok;
    t_tok n_tok;

    assign o_stall = r_vld && i_stall;
    assign o_valid = r_vld;
    assign o_tok   = r_tok;

    always_comb begin
        n_tok.fin = i_item.is_final;
        n_tok.val = SAMPLE_W'(i_item.count_a) + SAMPLE_W'(i_item.count_b)
                  + SAMPLE_W'(i_item.count_c) + SAMPLE_W'(i_item.count_d);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (!o_stall) begin
            r_vld <= i_valid;
        end
        if (!o_stall && i_valid) begin
            r_tok <= n_tok;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/cts_stage.sv */
`default_nettype none
module cts_stage
    import cts_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_tok i_tok,
    output logic      o_stall,
    output logic      o_valid,
    output t_tok      o_tok,
    input  wire logic i_stall
);

    typedef enum logic [1:0] {
        FILL_EMPTY,
        FILL_ONE,
        FILL_MORE
    } t_fill;

    t_fill               r_fill, n_fill;
    logic [SAMPLE_W-1:0] r_cur, n_cur;
    logic [SAMPLE_W-1:0] r_prev, n_prev;
    logic                r_out_vld, n_out_vld;
    t_tok                r_out_tok, n_out_tok;
    logic                r_pend, n_pend;
    logic [SAMPLE_W-1:0] r_pend_val, n_pend_val;

    logic                take_out;
    logic [SUM3_W-1:0]   sum3;
    logic [PROD_W-1:0]   prod;
    logic [SAMPLE_W-1:0] mean;

    assign take_out = !r_out_vld || !i_stall;
    assign o_stall  = r_pend || !take_out;
    assign o_valid  = r_out_vld;
    assign o_tok    = r_out_tok;

    assign sum3 = SUM3_W'(r_prev) + SUM3_W'(r_cur) + SUM3_W'(i_tok.val);
    assign prod = PROD_W'(sum3) * PROD_W'(DIV3_MUL);
    assign mean = (r_fill == FILL_ONE) ? r_cur : prod[DIV3_SHIFT +: SAMPLE_W];

    always_comb begin
        n_fill     = r_fill;
        n_cur      = r_cur;
        n_prev     = r_prev;
        n_out_vld  = r_out_vld && !take_out;
        n_out_tok  = r_out_tok;
        n_pend     = r_pend;
        n_pend_val = r_pend_val;
        if (r_pend && take_out) begin
            // second half of a flush: the final sample itself
            n_out_vld     = 1'b1;
            n_out_tok.fin = 1'b1;
            n_out_tok.val = r_pend_val;
            n_pend        = 1'b0;
        end else if (i_valid && !o_stall) begin
            unique case (r_fill)
                FILL_EMPTY: begin
                    if (i_tok.fin) begin
                        n_out_vld = 1'b1;
                        n_out_tok = i_tok;
                    end else begin
                        n_cur  = i_tok.val;
                        n_fill = FILL_ONE;
                    end
                end
                FILL_ONE, FILL_MORE: begin
                    n_out_vld     = 1'b1;
                    n_out_tok.fin = 1'b0;
                    n_out_tok.val = mean;
                    if (i_tok.fin) begin
                        n_fill     = FILL_EMPTY;
                        n_cur      = '0;
                        n_prev     = '0;
                        n_pend     = 1'b1;
                        n_pend_val = i_tok.val;
                    end else begin
                        n_prev = r_cur;
                        n_cur  = i_tok.val;
                        n_fill = FILL_MORE;
                    end
                end
                default: begin
                    n_fill = FILL_EMPTY;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= FILL_EMPTY;
            r_cur     <= '0;
            r_prev    <= '0;
            r_out_vld <= 1'b0;
            r_pend    <= 1'b0;
        end else begin
            r_fill    <= n_fill;
            r_cur     <= n_cur;
            r_prev    <= n_prev;
            r_out_vld <= n_out_vld;
            r_pend    <= n_pend;
        end
        r_out_tok  <= n_out_tok;
        r_pend_val <= n_pend_val;
    end

endmodule
`default_nettype wire

/* hw/rtl/cascaded_three_point_smoother_top.sv */
// Throughput: one item per cycle unless the output stalls; a final item also stalls the
//   input of each stage that still holds samples, since that stage sends its held mean
//   and the final sample in turn.
// Reset (synchronous, active low) empties every stage and drops all pending items;
//   held sample values clear to zero.
`default_nettype none
module cascaded_three_point_smoother_top
    import cts_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire t_in_item i_in_data,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output t_out_item     o_out_data,
    input  wire logic     i_out_stall
);

    // Handshake chain: index 0 is the adder output, index s+1 the output of stage s.
    logic vld   [PASSES+1];
    t_tok tok   [PASSES+1];
    logic stall [PASSES+1];

    // Add the four counts into one sample and register it.
    cts_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (i_in_data),
        .o_stall (o_in_stall),
        .o_valid (vld[0]),
        .o_tok   (tok[0]),
        .i_stall (stall[0])
    );

    // Smoothing cascade: each stage holds back one sample and flushes on the final item.
    for (genvar s = 0; s < PASSES; s++) begin : g_stage
        cts_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (vld[s]),
            .i_tok   (tok[s]),
            .o_stall (stall[s]),
            .o_valid (vld[s+1]),
            .o_tok   (tok[s+1]),
            .i_stall (stall[s+1])
        );
    end

    // The last stage's output register drives the result port.
    assign stall[PASSES]            = i_out_stall;
    assign o_out_valid              = vld[PASSES];
    assign o_out_data.smoothed      = tok[PASSES].val;
    assign o_out_data.ends_sequence = tok[PASSES].fin;

endmodule
`default_nettype wire

/* verif/smoother_checker.sv */
module smoother_checker
    import cts_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire t_in_item  i_in_data,
    input  wire logic      i_in_stall,
    input  wire logic      i_out_valid,
    input  wire t_out_item i_out_data,
    input  wire logic      i_out_stall,
    output int             o_pending,
    output int             o_mismatches
);

    localparam int SPAN       = 3;

    typedef struct packed {
        logic                last;
        logic [SAMPLE_W-1:0] val;
    } t_sample;

    logic [SAMPLE_W:0] held_cur  [PASSES];
    logic [SAMPLE_W:0] held_prev [PASSES];
    logic [1:0]        held_fill [PASSES];

    t_out_item smoothed_q[$];
    int        mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    task automatic report(input string what, input int got, input int want);
        $display("[%0t] smoother mismatch: %s got %0d want %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Run one item through every stage; queue the samples leaving the last one.
    task automatic predict_smoothed(input t_in_item it);
        t_sample             stage_in[$];
        t_sample             stage_out[$];
        t_sample             tk;
        logic [SAMPLE_W+1:0] span_sum;
        logic [SAMPLE_W-1:0] mean;
        int                  s;
        int                  k;

        tk.last = it.is_final;
        tk.val  = SAMPLE_W'(it.count_a) + SAMPLE_W'(it.count_b)
                + SAMPLE_W'(it.count_c) + SAMPLE_W'(it.count_d);
        stage_in.push_back(tk);
        for (s = 0; s < PASSES; s++) begin
            stage_out = {};
            for (k = 0; k < stage_in.size(); k++) begin
                tk = stage_in[k];
                if (held_fill[s] == 2'd0) begin
                    if (tk.last) begin
                        stage_out.push_back(tk);
                    end else begin
                        held_cur[s]  = {1'b0, tk.val};
                        held_fill[s] = 2'd1;
                    end
                end else begin
                    if (held_fill[s] == 2'd1) begin
                        mean = held_cur[s][SAMPLE_W-1:0];
                    end else begin
                        span_sum = held_prev[s] + held_cur[s] + tk.val;
                        mean     = SAMPLE_W'(span_sum / SPAN);
                    end
                    stage_out.push_back('{last: 1'b0, val: mean});
                    if (tk.last) begin
                        held_cur[s]  = '0;
                        held_prev[s] = '0;
                        held_fill[s] = 2'd0;
                        stage_out.push_back(tk);
                    end else begin
                        held_prev[s] = held_cur[s];
                        held_cur[s]  = {1'b0, tk.val};
                        held_fill[s] = 2'd2;
                    end
                end
            end
            stage_in = stage_out;
        end
        for (k = 0; k < stage_in.size(); k++)
            smoothed_q.push_back('{smoothed: stage_in[k].val, ends_sequence: stage_in[k].last});
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        int        s;

        if (!i_rst_n) begin
            for (s = 0; s < PASSES; s++) begin
                held_cur[s]  = '0;
                held_prev[s] = '0;
                held_fill[s] = 2'd0;
            end
            smoothed_q.delete();
            o_pending <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (smoothed_q.size() == 0) begin
                    report("unexpected result, smoothed", int'(i_out_data.smoothed), -1);
                end else begin
                    want = smoothed_q.pop_front();
                    if (i_out_data.smoothed !== want.smoothed)
                        report("smoothed", int'(i_out_data.smoothed), int'(want.smoothed));
                    if (i_out_data.ends_sequence !== want.ends_sequence)
                        report("ends_sequence", int'(i_out_data.ends_sequence),
                               int'(want.ends_sequence));
                end
            end
            if (i_in_valid && !i_in_stall)
                predict_smoothed(i_in_data);
            o_pending <= smoothed_q.size();
        end
    end

endmodule

/* verif/tb_cascaded_three_point_smoother_top.sv */
module tb_cascaded_three_point_smoother_top;
    import cts_pkg::*;

    localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
    localparam int                 MAX_WAIT   = 16;
    localparam int                 ITEM_GOAL  = 430;
    // quiet cycles allowed: sender gap + cascade latency + receiver stall, several times over
    localparam int                 IDLE_LIMIT = 1000;
    // trailing cycles once nothing is expected: catches stray results from the cascade
    localparam int                 TAIL       = 20;

    // content styles for a random sequence
    typedef enum int {
        FILL_RANDOM,
        FILL_EXTREME,
        FILL_SMALL,
        FILL_NEAR_MAX,
        FILL_MIXED
    } t_fill_style;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;

    int pending_results;
    int mismatches;
    int items_sent  = 0;
    int out_hold    = 0;
    int idle_cycles = 0;
    bit calm        = 1'b0;

    // Toggle the clock: one time unit high, one low.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    cascaded_three_point_smoother_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    smoother_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .i_in_stall   (o_in_stall),
        .i_out_valid  (o_out_valid),
        .i_out_data   (o_out_data),
        .i_out_stall  (i_out_stall),
        .o_pending    (pending_results),
        .o_mismatches (mismatches)
    );

    // Draw a wait for one item; a calm stretch runs back to back.
    function automatic int next_wait();
        return calm ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic logic [COUNT_W-1:0] pick_count(input t_fill_style style);
        case (style)
            FILL_EXTREME:  return $urandom_range(0, 1) ? COUNT_MAX : '0;
            FILL_SMALL:    return COUNT_W'($urandom_range(0, 15));
            FILL_NEAR_MAX: return COUNT_MAX - COUNT_W'($urandom_range(0, 3));
            FILL_MIXED:    return pick_count(t_fill_style'($urandom_range(0, 3)));
            default:       return COUNT_W'($urandom);
        endcase
    endfunction

    // Receiver side: hold stall for a drawn number of cycles after each accepted
    // result, and now and then while nothing is offered, so stalls land on every phase.
    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall)
            out_hold = next_wait();
        else if (!o_out_valid && out_hold == 0 && $urandom_range(0, 7) == 0)
            out_hold = next_wait();
        i_out_stall <= (out_hold != 0);
        if (out_hold != 0)
            out_hold = out_hold - 1;
    end

    // Watchdog: end the run when nothing moves on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Offer one item after a drawn gap and hold it until accepted. With no gap,
    // valid stays high and only the payload advances.
    task automatic send_item(input logic [COUNT_W-1:0] a, input logic [COUNT_W-1:0] b,
                             input logic [COUNT_W-1:0] c, input logic [COUNT_W-1:0] d,
                             input logic fin);
        int gap;

        gap = next_wait();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{count_a: a, count_b: b, count_c: c, count_d: d, is_final: fin};
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        items_sent++;
    endtask

    // Drop valid and hold off until every expected result has come back.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0)
            @(posedge i_clk);
    endtask

    // Send a sequence of random content; a ragged one places final marks at random
    // and may leave the cascade holding samples for the next sequence.
    task automatic send_random_seq();
        int          len;
        int          pick;
        int          k;
        bit          ragged;
        t_fill_style style;

        pick   = $urandom_range(0, 19);
        ragged = 1'b0;
        if (pick < 3)
            len = 1;
        else if (pick < 6)
            len = 2;
        else if (pick < 17)
            len = $urandom_range(3, 10);
        else if (pick < 19)
            len = $urandom_range(11, 40);
        else begin
            len    = $urandom_range(1, 12);
            ragged = 1'b1;
        end
        style = t_fill_style'($urandom_range(0, 4));
        for (k = 0; k < len; k++) begin
            send_item(pick_count(style), pick_count(style), pick_count(style),
                      pick_count(style),
                      ragged ? ($urandom_range(0, 3) == 0) : (k == len - 1));
        end
    endtask

    initial begin
        int k;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part runs back to back first.
        calm = 1'b1;
        // lone sample at the top of the range: passes through unchanged
        send_item(COUNT_MAX, COUNT_MAX, COUNT_MAX, COUNT_MAX, 1'b1);
        // lone zero sample
        send_item('0, '0, '0, '0, 1'b1);
        // two samples: both come out untouched
        send_item(COUNT_MAX, COUNT_MAX, COUNT_MAX, COUNT_MAX, 1'b0);
        send_item('0, '0, '0, '0, 1'b1);
        // three samples: a spike in the middle gets averaged down
        send_item('0, '0, '0, '0, 1'b0);
        send_item(COUNT_MAX, COUNT_MAX, COUNT_MAX, COUNT_MAX, 1'b0);
        send_item('0, '0, '0, '0, 1'b1);
        // full-scale plateau: widest three-point sums
        calm = 1'b0;
        for (k = 0; k < 5; k++)
            send_item(COUNT_MAX, COUNT_MAX, COUNT_MAX, COUNT_MAX, k == 4);
        // alternating extremes across the whole cascade
        for (k = 0; k < 7; k++) begin
            if (k % 2 == 1)
                send_item(COUNT_MAX, COUNT_MAX, COUNT_MAX, COUNT_MAX, k == 6);
            else
                send_item('0, '0, '0, '0, k == 6);
        end
        // one lane at a time carries the count
        send_item(COUNT_MAX, '0, '0, '0, 1'b0);
        send_item('0, COUNT_MAX, '0, '0, 1'b0);
        send_item('0, '0, COUNT_MAX, '0, 1'b0);
        send_item('0, '0, '0, COUNT_MAX, 1'b1);

        // Pause the sender until the cascade has flushed everything out.
        wait_drained();

        // Random part: mostly complete sequences, with calm stretches and pauses.
        while (items_sent < ITEM_GOAL) begin
            calm = ($urandom_range(0, 4) == 0);
            send_random_seq();
            if ($urandom_range(0, 11) == 0)
                wait_drained();
        end
        // close any ragged sequence still held in the cascade
        calm = 1'b0;
        send_item(pick_count(FILL_RANDOM), pick_count(FILL_RANDOM), pick_count(FILL_RANDOM),
                  pick_count(FILL_RANDOM), 1'b1);

        wait_drained();
        repeat (TAIL) @(posedge i_clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
